FILE: rtl/mlfd_pkg.sv
`default_nettype none

package mlfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [ByteW-1:0] START_MARKER   = 8'h3E;
  localparam logic [LenW-1:0]  MAX_LEN_RESET  = 16'd1024;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_LEN_ERROR = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_LEN_HI  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [ByteW-1:0] data;
    logic             last;
  } mlfd_result_t;

endpackage

`default_nettype wire

FILE: rtl/mlfd_parser.sv
`default_nettype none

module mlfd_parser
  import mlfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [LenW-1:0]  max_len_i,
  output mlfd_result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_lo_q, len_lo_d;
  logic [LenW-1:0]  exp_len_q, exp_len_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  count_inc;

  assign len       = {byte_i, len_lo_q};
  assign count_inc = count_q + LenW'(1);

  always_comb begin
    phase_d   = phase_q;
    len_lo_d  = len_lo_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    res_o     = '{valid: 1'b0, kind: KIND_PAYLOAD, data: '0, last: 1'b0};
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == START_MARKER) phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_d = byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len == '0 || len > max_len_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_LEN_ERROR;
          phase_d     = PH_HUNT;
        end else begin
          exp_len_d = len;
          count_d   = '0;
          phase_d   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        count_d     = count_inc;
        res_o.valid = 1'b1;
        res_o.data  = byte_i;
        res_o.last  = (count_inc >= exp_len_q);
        if (res_o.last) phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      len_lo_q  <= len_lo_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/marker_length_frame_deframer.sv
// Path: an accepted input item enters the input register; its result is loaded into the output register.
// Throughput: one input item per cycle; the input register holds only while a
//   result waits in the stalled output register.
// Reset (rst_ni low, asynchronous): the parser returns to hunting for the
//   start marker, both registers empty, max_frame_length back to 1024.
`default_nettype none

module marker_length_frame_deframer
  import mlfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic             result_kind_o,
  output      logic [ByteW-1:0] payload_byte_o,
  output      logic             frame_end_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [LenW-1:0]  cfg_max_frame_length_i
);

  logic [LenW-1:0]  max_len_q;
  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_adv;
  logic             in_accept;
  logic             out_load;
  logic             out_valid_q, out_valid_d;
  logic             kind_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  mlfd_result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_max_frame_length_i;
    end
  end

  mlfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_adv),
    .byte_i    (s1_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  // hold the item while its result cannot enter the stalled output register
  assign s1_adv     = s1_valid_q && !(res.valid && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_adv && res.valid;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_byte_q <= rx_byte_i;
    if (out_load) begin
      kind_q <= res.kind;
      data_q <= res.data;
      last_q <= res.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = data_q;
  assign frame_end_o    = last_q;

endmodule

`default_nettype wire

FILE: rtl/mlfd_checker.sv
`default_nettype none

module mlfd_checker
  import mlfd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             result_kind_o,
  input wire logic [ByteW-1:0] payload_byte_o,
  input wire logic             frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(payload_byte_o) && $stable(frame_end_o))
    else $error("stalled item changed");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_LEN_ERROR |-> payload_byte_o == '0 && !frame_end_o)
    else $error("error item carries payload");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without accepted item");

endmodule

bind marker_length_frame_deframer mlfd_checker u_mlfd_checker (.*);

`default_nettype wire

FILE: test/marker_length_frame_deframer_checker.sv
`timescale 1ns / 100ps

module marker_length_frame_deframer_checker
  import mlfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             result_kind_i,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic             frame_end_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [LenW-1:0]  cfg_max_frame_length_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o,
  output int unsigned      compared_o
);

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
    logic             last;
  } deframed_t;

  deframed_t        deframed_q[$];
  phase_e           phase;
  logic [ByteW-1:0] len_lo;
  logic [LenW-1:0]  frame_len;
  logic [LenW-1:0]  byte_count;
  logic [LenW-1:0]  max_len;
  int unsigned      mismatches = 0;
  int unsigned      compared = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 30) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic restart_hunt();
    phase = PH_HUNT;
    len_lo = '0;
    frame_len = '0;
    byte_count = '0;
  endtask

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    logic            last;
    case (phase)
      PH_HUNT: begin
        if (b == START_MARKER) phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo = b;
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len = {b, len_lo};
        if (len == '0 || len > max_len) begin
          restart_hunt();
          deframed_q.push_back(deframed_t'{kind: KIND_LEN_ERROR, data: '0, last: 1'b0});
        end else begin
          frame_len = len;
          byte_count = '0;
          phase = PH_PAYLOAD;
        end
      end
      default: begin
        byte_count = byte_count + 1'b1;
        last = (byte_count >= frame_len);
        deframed_q.push_back(deframed_t'{kind: KIND_PAYLOAD, data: b, last: last});
        if (last) restart_hunt();
      end
    endcase
  endtask

  task automatic check_result();
    deframed_t want;
    if (deframed_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected: kind %0d byte %02h end %0d",
                                result_kind_i, payload_byte_i, frame_end_i));
    end else begin
      want = deframed_q.pop_front();
      compared++;
      if (result_kind_i !== want.kind) begin
        report_mismatch($sformatf("result_kind %0d, want %0d", result_kind_i, want.kind));
      end
      if (payload_byte_i !== want.data) begin
        report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte_i, want.data));
      end
      if (frame_end_i !== want.last) begin
        report_mismatch($sformatf("frame_end %0d, want %0d", frame_end_i, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hunt();
      max_len = MAX_LEN_RESET;
      deframed_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_len = cfg_max_frame_length_i;
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
    end
    mismatch_count_o = mismatches;
    pending_o = deframed_q.size();
    compared_o = compared;
  end

endmodule

FILE: test/marker_length_frame_deframer_test.sv
`timescale 1ns / 100ps

module marker_length_frame_deframer_test;
  import mlfd_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             out_stall_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [LenW-1:0]  cfg_max_frame_length_i = MAX_LEN_RESET;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             result_kind_o;
  logic [ByteW-1:0] payload_byte_o;
  logic             frame_end_o;
  logic             cfg_ready_o;

  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      compared;

  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  logic [LenW-1:0]  cur_max = MAX_LEN_RESET;
  int unsigned      bytes_sent = 0;
  int unsigned      headers_sent = 0;

  marker_length_frame_deframer dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .rx_byte_i              (rx_byte_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .result_kind_o          (result_kind_o),
    .payload_byte_o         (payload_byte_o),
    .frame_end_o            (frame_end_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_max_frame_length_i (cfg_max_frame_length_i)
  );

  marker_length_frame_deframer_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .rx_byte_i              (rx_byte_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .result_kind_i          (result_kind_o),
    .payload_byte_i         (payload_byte_o),
    .frame_end_i            (frame_end_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_max_frame_length_i (cfg_max_frame_length_i),
    .mismatch_count_o       (mismatches),
    .pending_o              (pending),
    .compared_o             (compared)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end while (!taken);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return START_MARKER;
    if (r < 7) return 8'h00;
    if (r < 10) return 8'hFF;
    return ByteW'($urandom_range(255));
  endfunction

  function automatic logic [LenW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 14 && cur_max != 16'hFFFF) begin
      if ($urandom_range(1) != 0) return cur_max + 1'b1;
      return LenW'($urandom_range(32'(cur_max) + 1, 65535));
    end
    if (cur_max == '0) return LenW'($urandom_range(1, 65535));
    if (r < 20 && cur_max <= 16'd64) return cur_max;
    return LenW'($urandom_range(1, (cur_max < 16'd24) ? 32'(cur_max) : 24));
  endfunction

  task automatic send_frame(input logic [LenW-1:0] len, input bit cut);
    int unsigned n;
    send_byte(START_MARKER);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    headers_sent++;
    if (len != '0 && len <= cur_max) begin
      n = cut ? $urandom_range(0, 32'(len) - 1) : 32'(len);
      repeat (n) send_byte(pick_payload());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max(input logic [LenW-1:0] m);
    bit done;
    cfg_valid_i <= 1'b1;
    cfg_max_frame_length_i <= m;
    do begin
      @(posedge clk_i);
      done = cfg_ready_o;
    end while (!done);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_max = m;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    logic [ByteW-1:0] b;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 3)) begin
          b = ByteW'($urandom_range(255));
          if (b == START_MARKER && $urandom_range(1) != 0) b = 8'h3C;
          send_byte(b);
        end
      end
      send_frame(pick_length(), $urandom_range(99) < 8);
    end
  endtask

  initial begin
    logic [ByteW-1:0] opening_seq [$] = '{
      8'h00, 8'hFF, 8'h3D,
      START_MARKER, 8'h00, 8'h00,
      START_MARKER, 8'h01, 8'h04,
      START_MARKER, 8'h01, START_MARKER,
      START_MARKER, 8'hFF, 8'hFF,
      START_MARKER, 8'h02, 8'h00, START_MARKER, 8'h7F,
      START_MARKER, 8'h01, 8'h00, 8'h80
    };
    logic [LenW-1:0] max_table [8] = '{
      16'd1024, 16'd1, 16'd37, 16'hFFFF, 16'd0, 16'd9, 16'd300, 16'd2
    };
    logic [LenW-1:0] m;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    wait_drained();
    write_max(16'd0);
    send_frame(16'd1, 1'b0);
    send_frame(16'hFFFF, 1'b0);

    wait_drained();
    write_max(16'hFFFF);
    send_frame(16'h0101, 1'b0);

    send_byte(START_MARKER);
    send_byte(8'h05);
    send_byte(8'h00);
    repeat (2) send_byte(pick_payload());
    wait_drained();
    write_max(16'd1);
    repeat (3) send_byte(pick_payload());
    send_frame(16'd2, 1'b0);
    send_frame(16'd1, 1'b0);

    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct = 19;
          stall_pct = 19;
        end
      endcase
      for (int j = 0; j < 2; j++) begin
        m = (2 * mix + j == 6) ? LenW'($urandom_range(2, 65534)) : max_table[2 * mix + j];
        wait_drained();
        write_max(m);
        run_random(175);
      end
    end

    wait_drained();
    $display("Drove %0d bytes carrying %0d frame headers; compared %0d results.",
             bytes_sent, headers_sent, compared);
    $display("Maximum length swept over 0, 1, 2, 9, 37, 1024, 65535 and one random value.");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Run timed out with %0d results outstanding.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: marker_length_frame_deframer.f
rtl/mlfd_pkg.sv
rtl/mlfd_parser.sv
rtl/marker_length_frame_deframer.sv
rtl/mlfd_checker.sv
test/marker_length_frame_deframer_checker.sv
test/marker_length_frame_deframer_test.sv
